FILE: sv/lst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg: shared types for the LCD scanline mode timer
// Mode codes, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int unsigned CountW = 10;
  localparam int unsigned LineW  = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lst_mode_e;

  typedef enum logic [1:0] {
    REG_HBLANK_IRQ_EN = 2'd0,
    REG_VBLANK_IRQ_EN = 2'd1,
    REG_OAM_IRQ_EN    = 2'd2,
    REG_COIN_IRQ_EN   = 2'd3
  } lst_reg_e;

  typedef struct packed {
    lst_mode_e          mode;
    logic [CountW-1:0]  count;
    logic [LineW-1:0]   line;
    logic               coin;
  } lst_state_t;

  typedef struct packed {
    logic coin;
    logic oam;
    logic vblank;
    logic hblank;
  } lst_irq_en_t;

  typedef struct packed {
    logic vblank_req;
    logic lcd_req;
    logic render;
    logic frame;
  } lst_flags_t;

endpackage

FILE: sv/lst_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_step: next-state logic for one tick
// Adds the elapsed cycles, takes at most one mode step and checks coincidence.
// ----------------------------------------------------------------------------
module lst_step #(
  parameter int unsigned OAM_CYCLES         = 80,
  parameter int unsigned TRANSFER_CYCLES    = 172,
  parameter int unsigned HBLANK_CYCLES      = 204,
  parameter int unsigned VBLANK_LINE_CYCLES = 456,
  parameter int unsigned VISIBLE_LINES      = 144,
  parameter int unsigned LAST_LINE          = 153
) (
  input  lst_pkg::lst_state_t  state_i,
  input  lst_pkg::lst_irq_en_t irq_en_i,
  input  logic [5:0]           elapsed_i,
  input  logic                 enable_i,
  input  logic [7:0]           compare_i,
  output lst_pkg::lst_state_t  state_o,
  output lst_pkg::lst_flags_t  flags_o
);

  localparam int unsigned CW = lst_pkg::CountW;
  localparam int unsigned LW = lst_pkg::LineW;
  localparam logic [CW-1:0] OamThr    = CW'(OAM_CYCLES);
  localparam logic [CW-1:0] XferThr   = CW'(TRANSFER_CYCLES);
  localparam logic [CW-1:0] HblankThr = CW'(HBLANK_CYCLES);
  localparam logic [CW-1:0] VblankThr = CW'(VBLANK_LINE_CYCLES);
  localparam logic [LW:0]   VisLines  = (LW+1)'(VISIBLE_LINES);
  localparam logic [LW:0]   LastLine  = (LW+1)'(LAST_LINE);

  logic [CW:0]   sum;
  logic [CW-1:0] count_sat;
  logic [LW:0]   line_inc;

  assign sum       = {1'b0, state_i.count} + {{(CW-5){1'b0}}, elapsed_i};
  assign count_sat = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  assign line_inc  = {1'b0, state_i.line} + {{LW{1'b0}}, 1'b1};

  always_comb begin
    state_o = state_i;
    flags_o = '0;
    if (enable_i) begin
      state_o.count = count_sat;
      case (state_i.mode)
        lst_pkg::MODE_OAM: begin
          if (count_sat >= OamThr) begin
            state_o.count = '0;
            state_o.mode  = lst_pkg::MODE_XFER;
          end
        end
        lst_pkg::MODE_XFER: begin
          if (count_sat >= XferThr) begin
            state_o.count   = '0;
            state_o.mode    = lst_pkg::MODE_HBLANK;
            flags_o.render  = 1'b1;
            flags_o.lcd_req = irq_en_i.hblank;
          end
        end
        lst_pkg::MODE_HBLANK: begin
          if (count_sat >= HblankThr) begin
            state_o.count = '0;
            state_o.line  = line_inc[LW-1:0];
            if (line_inc == VisLines) begin
              state_o.mode       = lst_pkg::MODE_VBLANK;
              flags_o.frame      = 1'b1;
              flags_o.vblank_req = 1'b1;
              flags_o.lcd_req    = irq_en_i.vblank;
            end else begin
              state_o.mode    = lst_pkg::MODE_OAM;
              flags_o.lcd_req = irq_en_i.oam;
            end
          end
        end
        default: begin
          if (count_sat >= VblankThr) begin
            state_o.count = '0;
            if (line_inc > LastLine) begin
              // Frame wraps; the line compare below then sees line 0.
              state_o.line    = '0;
              state_o.mode    = lst_pkg::MODE_OAM;
              flags_o.lcd_req = irq_en_i.oam;
            end else begin
              state_o.line = line_inc[LW-1:0];
            end
          end
        end
      endcase
      state_o.coin = (state_o.line == compare_i);
      if (state_o.coin && irq_en_i.coin) begin
        flags_o.lcd_req = 1'b1;
      end
    end
  end

endmodule

FILE: sv/lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer: LCD scanline mode and line timing
// Steps OAM search, pixel transfer, hblank and vblank per tick, and gives
// the status byte, interrupt requests and render/frame pulses.
// ----------------------------------------------------------------------------
//  Channel  Signals                                     Direction
//  -------  ------------------------------------------  ---------
//  tick     in_valid_i/in_ready_o + 3 fields             in
//  result   out_valid_o/out_ready_i + 8 fields           out
//  config   cfg_we_i, cfg_index_i, cfg_data_i            in
//
// One tick per cycle unless stalled; its result appears in the next cycle.
// The timing state updates at the input transfer, the result sits in the
// output register. A stalled output only blocks input when it is full and
// not being taken. Reset: vblank mode, line 0, counter 0, enables off.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer #(
  parameter int unsigned OAM_CYCLES         = 80,
  parameter int unsigned TRANSFER_CYCLES    = 172,
  parameter int unsigned HBLANK_CYCLES      = 204,
  parameter int unsigned VBLANK_LINE_CYCLES = 456,
  parameter int unsigned VISIBLE_LINES      = 144,
  parameter int unsigned LAST_LINE          = 153
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] elapsed_cycles_i,
  input  logic       lcd_enable_i,
  input  logic [7:0] line_compare_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] mode_o,
  output logic [7:0] line_o,
  output logic       coincidence_o,
  output logic [6:0] status_byte_o,
  output logic       vblank_request_o,
  output logic       lcd_request_o,
  output logic       line_render_start_o,
  output logic       frame_done_o
);

  lst_pkg::lst_irq_en_t irq_en_q;
  lst_pkg::lst_state_t  state_q, state_d;
  lst_pkg::lst_flags_t  flags_d, flags_q;
  logic                 out_valid_q;
  logic                 in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lst_pkg::REG_HBLANK_IRQ_EN: irq_en_q.hblank <= cfg_data_i;
        lst_pkg::REG_VBLANK_IRQ_EN: irq_en_q.vblank <= cfg_data_i;
        lst_pkg::REG_OAM_IRQ_EN:    irq_en_q.oam    <= cfg_data_i;
        lst_pkg::REG_COIN_IRQ_EN:   irq_en_q.coin   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lst_step #(
    .OAM_CYCLES        (OAM_CYCLES),
    .TRANSFER_CYCLES   (TRANSFER_CYCLES),
    .HBLANK_CYCLES     (HBLANK_CYCLES),
    .VBLANK_LINE_CYCLES(VBLANK_LINE_CYCLES),
    .VISIBLE_LINES     (VISIBLE_LINES),
    .LAST_LINE         (LAST_LINE)
  ) u_step (
    .state_i  (state_q),
    .irq_en_i (irq_en_q),
    .elapsed_i(elapsed_cycles_i),
    .enable_i (lcd_enable_i),
    .compare_i(line_compare_i),
    .state_o  (state_d),
    .flags_o  (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= lst_pkg::MODE_VBLANK;
      state_q.count <= '0;
      state_q.line  <= '0;
      state_q.coin  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload flags; the mode, line and coin fields mirror state_q.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = state_q.mode;
  assign line_o              = state_q.line;
  assign coincidence_o       = state_q.coin;
  assign status_byte_o       = {irq_en_q.coin, irq_en_q.oam, irq_en_q.vblank,
                                irq_en_q.hblank, state_q.coin, state_q.mode};
  assign vblank_request_o    = flags_q.vblank_req;
  assign lcd_request_o       = flags_q.lcd_req;
  assign line_render_start_o = flags_q.render;
  assign frame_done_o        = flags_q.frame;

endmodule

FILE: tb/tb_lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_scanline_mode_timer: self-checking bench for the scanline mode timer
// A queue-fed driver sends tick transfers and a monitor predicts each result
// from its own copy of the timing state and compares it with the output.
// Runs a directed opening and then random ticks weighted toward long elapsed
// counts, so that vertical blank ends, the wrap to line 0 is taken and the
// visible lines that follow it are reached.
// ----------------------------------------------------------------------------
module tb_lcd_scanline_mode_timer;

  localparam int unsigned OamCycles      = 80;
  localparam int unsigned TransferCycles = 172;
  localparam int unsigned HblankCycles   = 204;
  localparam int unsigned VblankCycles   = 456;
  localparam int unsigned VisibleLines   = 144;
  localparam int unsigned LastLine       = 153;
  localparam int unsigned CountMax       = 1023;
  localparam int unsigned TicksPerPhase  = 520;
  localparam int unsigned StallLimit     = 4000;

  typedef struct packed {
    logic [5:0] elapsed;
    logic       enable;
    logic [7:0] compare;
  } scan_tick_t;

  typedef struct packed {
    lst_pkg::lst_mode_e mode;
    logic [7:0]         line;
    logic               coin;
    logic [6:0]         status;
    logic               vblank_req;
    logic               lcd_req;
    logic               render;
    logic               frame;
  } scan_status_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic       cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [5:0] elapsed_cycles_i;
  logic       lcd_enable_i;
  logic [7:0] line_compare_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] mode_o;
  logic [7:0] line_o;
  logic       coincidence_o;
  logic [6:0] status_byte_o;
  logic       vblank_request_o;
  logic       lcd_request_o;
  logic       line_render_start_o;
  logic       frame_done_o;

  lcd_scanline_mode_timer #(
    .OAM_CYCLES        (OamCycles),
    .TRANSFER_CYCLES   (TransferCycles),
    .HBLANK_CYCLES     (HblankCycles),
    .VBLANK_LINE_CYCLES(VblankCycles),
    .VISIBLE_LINES     (VisibleLines),
    .LAST_LINE         (LastLine)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .elapsed_cycles_i   (elapsed_cycles_i),
    .lcd_enable_i       (lcd_enable_i),
    .line_compare_i     (line_compare_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .mode_o             (mode_o),
    .line_o             (line_o),
    .coincidence_o      (coincidence_o),
    .status_byte_o      (status_byte_o),
    .vblank_request_o   (vblank_request_o),
    .lcd_request_o      (lcd_request_o),
    .line_render_start_o(line_render_start_o),
    .frame_done_o       (frame_done_o)
  );

  scan_tick_t   pending_ticks[$];
  scan_status_t expected_status[$];

  // Shadow of the timing state and the interrupt enables.
  lst_pkg::lst_mode_e   cur_mode;
  logic [9:0]           mode_count;
  logic [7:0]           cur_line;
  logic                 coin_flag;
  lst_pkg::lst_irq_en_t irq_en;

  int unsigned frames_seen;
  logic        wrapped_after_frame;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        in_taken;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  function automatic scan_status_t advance_scanline(scan_tick_t t);
    scan_status_t res;
    int unsigned  sum;
    logic [8:0]   next_line;
    res = '0;
    if (t.enable) begin
      sum = mode_count + t.elapsed;
      mode_count = (sum > CountMax) ? 10'(CountMax) : 10'(sum);
      case (cur_mode)
        lst_pkg::MODE_OAM: begin
          if (mode_count >= OamCycles) begin
            mode_count = '0;
            cur_mode = lst_pkg::MODE_XFER;
          end
        end
        lst_pkg::MODE_XFER: begin
          if (mode_count >= TransferCycles) begin
            mode_count = '0;
            cur_mode = lst_pkg::MODE_HBLANK;
            res.render = 1'b1;
            if (irq_en.hblank) res.lcd_req = 1'b1;
          end
        end
        lst_pkg::MODE_HBLANK: begin
          if (mode_count >= HblankCycles) begin
            mode_count = '0;
            next_line = {1'b0, cur_line} + 9'd1;
            cur_line = next_line[7:0];
            if (next_line == VisibleLines) begin
              cur_mode = lst_pkg::MODE_VBLANK;
              res.frame = 1'b1;
              res.vblank_req = 1'b1;
              if (irq_en.vblank) res.lcd_req = 1'b1;
              frames_seen++;
            end else begin
              cur_mode = lst_pkg::MODE_OAM;
              if (irq_en.oam) res.lcd_req = 1'b1;
            end
          end
        end
        default: begin
          if (mode_count >= VblankCycles) begin
            mode_count = '0;
            next_line = {1'b0, cur_line} + 9'd1;
            if (next_line > LastLine) begin
              // End of the frame: back to line 0 before the compare below.
              cur_line = '0;
              cur_mode = lst_pkg::MODE_OAM;
              if (irq_en.oam) res.lcd_req = 1'b1;
              if (frames_seen > 0) wrapped_after_frame = 1'b1;
            end else begin
              cur_line = next_line[7:0];
            end
          end
        end
      endcase
      if (cur_line == t.compare) begin
        coin_flag = 1'b1;
        if (irq_en.coin) res.lcd_req = 1'b1;
      end else begin
        coin_flag = 1'b0;
      end
    end
    res.mode   = cur_mode;
    res.line   = cur_line;
    res.coin   = coin_flag;
    res.status = {irq_en, coin_flag, cur_mode};
    return res;
  endfunction

  // Mostly long elapsed counts keep the frame moving; the compare value
  // tracks the current line often enough to hit coincidences.
  function automatic scan_tick_t random_tick();
    scan_tick_t  t;
    int unsigned pick;
    t.enable = ($urandom_range(99) < 92);
    pick = $urandom_range(99);
    if (pick < 70) t.elapsed = 6'd63;
    else if (pick < 85) t.elapsed = 6'($urandom_range(62, 40));
    else if (pick < 93) t.elapsed = 6'($urandom_range(63, 0));
    else t.elapsed = 6'($urandom_range(7, 0));
    pick = $urandom_range(99);
    if (pick < 35) t.compare = cur_line;
    else if (pick < 45) t.compare = cur_line + 8'd1;
    else if (pick < 55) t.compare = 8'd0;
    else if (pick < 62) begin
      case ($urandom_range(3))
        0: t.compare = 8'(VisibleLines);
        1: t.compare = 8'(LastLine);
        2: t.compare = 8'(LastLine + 1);
        default: t.compare = 8'hFF;
      endcase
    end else t.compare = 8'($urandom());
    return t;
  endfunction

  task automatic push_tick(input logic [5:0] elapsed, input logic enable,
                           input logic [7:0] compare);
    scan_tick_t t;
    t.elapsed = elapsed;
    t.enable  = enable;
    t.compare = compare;
    pending_ticks.push_back(t);
  endtask

  task automatic write_irq_enables(input lst_pkg::lst_irq_en_t en);
    lst_pkg::lst_reg_e idx;
    for (int i = 0; i < 4; i++) begin
      idx = lst_pkg::lst_reg_e'(i);
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      case (idx)
        lst_pkg::REG_HBLANK_IRQ_EN: cfg_data_i <= en.hblank;
        lst_pkg::REG_VBLANK_IRQ_EN: cfg_data_i <= en.vblank;
        lst_pkg::REG_OAM_IRQ_EN:    cfg_data_i <= en.oam;
        default:                    cfg_data_i <= en.coin;
      endcase
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    irq_en = en;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_random_ticks(input logic to_frame_end);
    scan_tick_t  t;
    int unsigned sent;
    sent = 0;
    while (sent < TicksPerPhase || (to_frame_end && !wrapped_after_frame)) begin
      @(negedge clk_i);
      if (pending_ticks.size() < 2) begin
        t = random_tick();
        pending_ticks.push_back(t);
        if (t.enable) sent++;
      end
    end
  endtask

  // Tick driver: a new transfer is offered only once the previous one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        scan_tick_t t;
        t = pending_ticks.pop_front();
        in_valid_i       <= 1'b1;
        elapsed_cycles_i <= t.elapsed;
        lcd_enable_i     <= t.enable;
        line_compare_i   <= t.compare;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk_i) begin
    scan_status_t exp_res;
    scan_status_t act_res;
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o)
      expected_status.push_back(advance_scanline(
          {elapsed_cycles_i, lcd_enable_i, line_compare_i}));
    if (out_valid_o && out_ready_i) begin
      act_res = {mode_o, line_o, coincidence_o, status_byte_o, vblank_request_o,
                 lcd_request_o, line_render_start_o, frame_done_o};
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing expected: %h", $realtime, act_res);
      end else begin
        exp_res = expected_status.pop_front();
        if (act_res !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("%0t: mismatch exp mode=%0d line=%0d coin=%b status=%h ",
                   $realtime, exp_res.mode, exp_res.line, exp_res.coin,
                   exp_res.status);
            $write("vreq=%b lreq=%b render=%b frame=%b | ", exp_res.vblank_req,
                   exp_res.lcd_req, exp_res.render, exp_res.frame);
            $write("got mode=%0d line=%0d coin=%b status=%h ", act_res.mode,
                   act_res.line, act_res.coin, act_res.status);
            $display("vreq=%b lreq=%b render=%b frame=%b", act_res.vblank_req,
                     act_res.lcd_req, act_res.render, act_res.frame);
          end
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL lcd_scanline_mode_timer");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = lst_pkg::REG_HBLANK_IRQ_EN;
    cfg_data_i          = 1'b0;
    in_valid_i          = 1'b0;
    elapsed_cycles_i    = '0;
    lcd_enable_i        = 1'b0;
    line_compare_i      = '0;
    out_ready_i         = 1'b0;
    in_taken            = 1'b0;
    cur_mode            = lst_pkg::MODE_VBLANK;
    mode_count          = '0;
    cur_line            = '0;
    coin_flag           = 1'b0;
    irq_en              = '0;
    frames_seen         = 0;
    wrapped_after_frame = 1'b0;
    mismatches          = 0;
    stall_cycles        = 0;
    send_idle_pct       = 24;
    recv_idle_pct       = 75;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening from reset (vertical blank, line 0), all enables on.
    write_irq_enables(4'b1111);
    push_tick(6'd0, 1'b1, 8'd0);      // coincidence on line 0 with no elapsed time
    push_tick(6'd63, 1'b1, 8'hFF);
    push_tick(6'd63, 1'b0, 8'd0);     // disabled: held state, no requests
    push_tick(6'h2A, 1'b1, 8'hAA);
    push_tick(6'h15, 1'b1, 8'h55);
    push_tick(6'd1, 1'b0, 8'hFF);
    push_tick(6'd63, 1'b1, 8'd1);
    for (int i = 0; i < 6; i++) push_tick(6'd63, 1'b1, 8'd1);
    push_tick(6'd63, 1'b1, 8'd153);
    push_tick(6'd0, 1'b1, 8'd144);
    push_tick(6'd63, 1'b0, 8'd1);
    wait_drained();

    write_irq_enables(4'b0000);
    run_random_ticks(1'b0);
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 24;
    write_irq_enables(4'b0101);
    run_random_ticks(1'b0);
    wait_drained();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_irq_enables(4'b1110);
    run_random_ticks(1'b0);
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS lcd_scanline_mode_timer");
    end else begin
      $display("FAIL lcd_scanline_mode_timer");
    end
    $finish;
  end

endmodule
